// ===== rtl/ddfs_pkg.sv =====
`timescale 1ns / 1ps
package ddfs_pkg;

  localparam int ID_W           = 8;
  localparam int RND_W          = 8;
  localparam int DIV_CNT_W      = $clog2(RND_W);
  localparam int NEIGHBOR_REGS  = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;
  localparam int MAX_NEIGHBORS_DEFAULT = 4;
  localparam int NODE_BITS_DEFAULT     = 8;

  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_TRAVERSE = 2'd1;
  localparam logic [1:0] CMD_RETURN   = 2'd2;

  localparam logic MSG_TRAVERSE = 1'b0;
  localparam logic MSG_RETURN   = 1'b1;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_IGNORED     = 2'd1;
  localparam logic [1:0] STAT_NO_NEIGHBOR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IS_ROOT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_3     = 3'd5;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  sender;
    logic [RND_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic            send_valid;
    logic            msg_kind;
    logic [ID_W-1:0] dest;
    logic            node_done;
    logic            walk_end;
    logic [1:0]      status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_COUNT,
    S_EVAL,
    S_MOD,
    S_PICK,
    S_FIN
  } fsm_state_t;

  typedef struct packed {
    logic load_item;
    logic drop;
    logic count;
    logic div_start;
    logic div_step;
    logic pick;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_pick;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/ddfs_ctrl.sv =====
`timescale 1ns / 1ps
module ddfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ddfs_pkg::dp_status_t sts,
  output ddfs_pkg::ctrl_cmd_t  ctl
);
  import ddfs_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DROP;
        end
      end
      S_DROP: begin
        ctl.drop   = 1'b1;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        ctl.count  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.need_pick) begin
          ctl.div_start = 1'b1;
          state_next    = S_MOD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MOD: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        ctl.pick   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ddfs_datapath.sv =====
`timescale 1ns / 1ps
module ddfs_datapath #(
  parameter int MAX_NEIGHBORS = ddfs_pkg::MAX_NEIGHBORS_DEFAULT,
  parameter int NODE_BITS     = ddfs_pkg::NODE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ddfs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ddfs_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [ddfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  ddfs_pkg::ctrl_cmd_t               ctl,
  output ddfs_pkg::dp_status_t              sts
);
  import ddfs_pkg::*;

  localparam int ENTRIES = (MAX_NEIGHBORS < NEIGHBOR_REGS) ? MAX_NEIGHBORS : NEIGHBOR_REGS;
  localparam int NB      = (NODE_BITS < ID_W) ? NODE_BITS : ID_W;
  localparam int CW      = $clog2(ENTRIES + 1);

  logic            is_root;
  logic [2:0]      neighbor_count;
  logic [ID_W-1:0] neighbor_id [NEIGHBOR_REGS];

  logic               visited;
  logic               has_parent;
  logic [NB-1:0]      parent_node;
  logic [ENTRIES-1:0] used_mask;
  logic               finished;

  logic [1:0]           cmd_q;
  logic [NB-1:0]        who_q;
  logic [RND_W-1:0]     rnd_q;
  logic [CW-1:0]        rem_q;
  logic [CW-1:0]        rmd_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [NB-1:0]        pick_q;

  logic [CW-1:0]      limit;
  logic [ENTRIES-1:0] live;
  logic [ENTRIES-1:0] drop_mask;
  logic               drop_found;
  logic [CW-1:0]      rem_calc;
  logic [CW:0]        trial;
  logic [CW-1:0]      pick_cnt;
  logic               pick_found;
  logic [NB-1:0]      pick_calc;
  logic               ignored;

  out_item_t     res;
  logic          visited_next;
  logic          has_parent_next;
  logic [NB-1:0] parent_node_next;
  logic          finished_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_root        <= 1'b0;
      neighbor_count <= '0;
      for (int i = 0; i < NEIGHBOR_REGS; i++) begin
        neighbor_id[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IS_ROOT:        is_root        <= cfg_data[0];
        REG_NEIGHBOR_COUNT: neighbor_count <= cfg_data[2:0];
        REG_NEIGHBOR_0:     neighbor_id[0] <= cfg_data;
        REG_NEIGHBOR_1:     neighbor_id[1] <= cfg_data;
        REG_NEIGHBOR_2:     neighbor_id[2] <= cfg_data;
        REG_NEIGHBOR_3:     neighbor_id[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (neighbor_count > 3'(ENTRIES)) begin
      limit = CW'(ENTRIES);
    end else begin
      limit = CW'(neighbor_count);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      live[i] = (CW'(i) < limit) && !used_mask[i];
    end
  end

  assign ignored = finished || (cmd_q != CMD_START && cmd_q != CMD_TRAVERSE &&
                   cmd_q != CMD_RETURN) || (cmd_q == CMD_START && (!is_root || visited));

  // first live entry that matches the sender
  always_comb begin
    drop_mask  = '0;
    drop_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!drop_found && live[i] && neighbor_id[i][NB-1:0] == who_q) begin
        drop_mask[i] = 1'b1;
        drop_found   = 1'b1;
      end
    end
  end

  always_comb begin
    rem_calc = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rem_calc = rem_calc + CW'(live[i]);
    end
  end

  assign trial = {rmd_q, rnd_q[RND_W-1]};

  always_comb begin
    pick_cnt   = '0;
    pick_found = 1'b0;
    pick_calc  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (live[i] && !pick_found) begin
        if (pick_cnt == rmd_q) begin
          pick_calc  = neighbor_id[i][NB-1:0];
          pick_found = 1'b1;
        end
        pick_cnt = pick_cnt + CW'(1);
      end
    end
  end

  assign sts.need_pick = !ignored && rem_q != '0 &&
                         (cmd_q == CMD_START || cmd_q == CMD_RETURN ||
                          (cmd_q == CMD_TRAVERSE && !visited));
  assign sts.div_last  = (div_cnt == DIV_CNT_W'(RND_W - 1));
  assign sts.out_free  = !out_valid || !out_stall;

  always_comb begin
    res              = '0;
    visited_next     = visited;
    has_parent_next  = has_parent;
    parent_node_next = parent_node;
    finished_next    = finished;
    if (ignored) begin
      res.status = STAT_IGNORED;
    end else begin
      case (cmd_q)
        CMD_START: begin
          if (rem_q == '0) begin
            res.status = STAT_NO_NEIGHBOR;
          end else begin
            visited_next   = 1'b1;
            res.send_valid = 1'b1;
            res.msg_kind   = MSG_TRAVERSE;
            res.dest       = ID_W'(pick_q);
          end
        end
        CMD_TRAVERSE: begin
          res.send_valid = 1'b1;
          if (!visited) begin
            visited_next     = 1'b1;
            has_parent_next  = 1'b1;
            parent_node_next = who_q;
            if (rem_q == '0) begin
              res.msg_kind  = MSG_RETURN;
              res.dest      = ID_W'(who_q);
              finished_next = 1'b1;
            end else begin
              res.msg_kind = MSG_TRAVERSE;
              res.dest     = ID_W'(pick_q);
            end
          end else begin
            res.msg_kind = MSG_RETURN;
            res.dest     = ID_W'(who_q);
          end
        end
        CMD_RETURN: begin
          if (rem_q == '0) begin
            if (has_parent) begin
              res.send_valid = 1'b1;
              res.msg_kind   = MSG_RETURN;
              res.dest       = ID_W'(parent_node);
            end else begin
              res.walk_end = 1'b1;
            end
            finished_next = 1'b1;
          end else begin
            res.send_valid = 1'b1;
            res.msg_kind   = MSG_TRAVERSE;
            res.dest       = ID_W'(pick_q);
          end
        end
        default: begin
          res.status = STAT_IGNORED;
        end
      endcase
    end
    res.node_done = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited     <= 1'b0;
      has_parent  <= 1'b0;
      parent_node <= '0;
      used_mask   <= '0;
      finished    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (ctl.drop && !ignored && (cmd_q == CMD_TRAVERSE || cmd_q == CMD_RETURN)) begin
        used_mask <= used_mask | drop_mask;
      end
      if (ctl.finish) begin
        visited     <= visited_next;
        has_parent  <= has_parent_next;
        parent_node <= parent_node_next;
        finished    <= finished_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q <= in_data.cmd;
      who_q <= in_data.sender[NB-1:0];
      rnd_q <= in_data.random_value;
    end else if (ctl.div_step) begin
      rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
    end
    if (ctl.count) begin
      rem_q <= rem_calc;
    end
    if (ctl.div_start) begin
      rmd_q   <= '0;
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      if (trial >= {1'b0, rem_q}) begin
        rmd_q <= CW'(trial - {1'b0, rem_q});
      end else begin
        rmd_q <= trial[CW-1:0];
      end
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (ctl.pick) begin
      pick_q <= pick_calc;
    end
    if (ctl.finish) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/distributed_dfs_node.sv =====
`timescale 1ns / 1ps
// One node of a token-passing depth-first walk over a graph.
// Input channel (in_valid / in_stall / in_data): one beat per received event,
// a start command at the root or a traverse / return message with its sender
// and a random value that picks the next neighbor among those left.
// Output channel (out_valid / out_stall / out_data): one beat per input beat,
// carrying the message to send (if any), node_done, walk_end and a status code.
// Configuration: cfg_we writes cfg_data into the register at cfg_index (is_root,
// neighbor_count, neighbor_0..3); write only while no beat is in flight.
// Sequence: after input accept the controller steps through drop, count and
// evaluate states, then, when a neighbor is picked, a one-bit-per-cycle modulo
// unit and a pick state, before a finish state loads the output register; the
// controller works on one beat at a time.
// Stall: the result sits in an output register; the controller takes the next
// input beat while it waits, but holds its own result until that register frees.
// Reset (rst, synchronous): configuration and node state clear to zero, no
// output beat is pending and the node is ready for input.
module distributed_dfs_node #(
  parameter int MAX_NEIGHBORS = ddfs_pkg::MAX_NEIGHBORS_DEFAULT,
  parameter int NODE_BITS     = ddfs_pkg::NODE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ddfs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ddfs_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ddfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ddfs_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  ddfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ddfs_datapath #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .NODE_BITS     (NODE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
